// File: rtl/sexp_tok_pkg.sv
// Package for the s-expression tokenizer: widths, byte codes, result kinds
// and the saturating counter helpers. No dependencies.
package sexp_tok_pkg;

    localparam int NEST_BITS   = 8;
    localparam int LENGTH_BITS = 16;
    localparam int LINE_BITS   = 16;

    // Width of the reported length and line fields (fixed by the port list)
    localparam int OUT_BITS = 16;

    localparam logic [NEST_BITS-1:0]   NEST_TOP = {NEST_BITS{1'b1}};
    localparam logic [LENGTH_BITS-1:0] LEN_TOP  = {LENGTH_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0]   LINE_TOP = {LINE_BITS{1'b1}};

    localparam int LEN_EXT_BITS  = (LENGTH_BITS > OUT_BITS) ? LENGTH_BITS : OUT_BITS;
    localparam int LINE_EXT_BITS = (LINE_BITS > OUT_BITS) ? LINE_BITS : OUT_BITS;

    // Source byte codes
    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_RPAREN    = 8'h29;
    localparam logic [7:0] CH_SEMI      = 8'h3B;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE     = 8'h27;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    // Result byte kinds
    localparam logic [2:0] KIND_WS      = 3'd0;
    localparam logic [2:0] KIND_OPEN    = 3'd1;
    localparam logic [2:0] KIND_CLOSE   = 3'd2;
    localparam logic [2:0] KIND_ATOM    = 3'd3;
    localparam logic [2:0] KIND_STRING  = 3'd4;
    localparam logic [2:0] KIND_QLIST   = 3'd5;
    localparam logic [2:0] KIND_COMMENT = 3'd6;

    function automatic logic [LENGTH_BITS-1:0] len_inc(input logic [LENGTH_BITS-1:0] v);
        return (v == LEN_TOP) ? v : v + LENGTH_BITS'(1);
    endfunction

    function automatic logic [LINE_BITS-1:0] line_inc(input logic [LINE_BITS-1:0] v);
        return (v == LINE_TOP) ? v : v + LINE_BITS'(1);
    endfunction

    function automatic logic [OUT_BITS-1:0] len_clip(input logic [LENGTH_BITS-1:0] v);
        logic [LEN_EXT_BITS-1:0] ext;
        ext = LEN_EXT_BITS'(v);
        return (ext > LEN_EXT_BITS'({OUT_BITS{1'b1}})) ? {OUT_BITS{1'b1}} : ext[OUT_BITS-1:0];
    endfunction

    function automatic logic [OUT_BITS-1:0] line_clip(input logic [LINE_BITS-1:0] v);
        logic [LINE_EXT_BITS-1:0] ext;
        ext = LINE_EXT_BITS'(v);
        return (ext > LINE_EXT_BITS'({OUT_BITS{1'b1}})) ? {OUT_BITS{1'b1}} : ext[OUT_BITS-1:0];
    endfunction

endpackage

// File: rtl/s_expression_tokenizer.sv
// S-expression tokenizer top level: input register, per-byte classifier
// and mode tracker, result register. Depends on sexp_tok_pkg.
//
// Takes one source byte per transaction and returns exactly one result
// transaction per byte, in order. Throughput is one byte per clock while
// the output is not stalled. A byte's result passes through the input
// register, which takes it at acceptance, and then the result register,
// which takes it once that register is free. The rate is set by the
// mode and counter update loop: each byte reads
// the state left by the byte before it. While the result register is full
// and stalled, one more byte is held in the input register; the input
// stalls only when both are occupied and the output is stalled. Tokens are
// flagged at their first byte (token_first) and where they close, either
// including the byte (ends_here: lone paren, closing quote, balancing paren
// of a quoted list, or a token still open at the last byte) or just before
// it (ended_before: an atom cut off by whitespace, ';' or a paren).
// token_length and line_number saturate at 16 bits. A byte with last set
// closes any open token, raises unclosed if it was a string or quoted list,
// and returns all tokenizer state to its reset values. No configuration.
module s_expression_tokenizer (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        last,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  byte_kind,
    output logic        token_first,
    output logic        ends_here,
    output logic        ended_before,
    output logic [15:0] token_length,
    output logic [15:0] line_number,
    output logic        depth_overflow,
    output logic        unclosed
);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_COMMENT,
        MODE_ATOM,
        MODE_STRING,
        MODE_QLIST
    } mode_t;

    // ---------------- tokenizer state ----------------
    mode_t                                mode_reg, mode_next;
    logic                                 pq_reg, pq_next;     // previous byte was a quote mark
    logic                                 pb_reg, pb_next;     // previous byte was a backslash
    logic [sexp_tok_pkg::NEST_BITS-1:0]   nest_reg, nest_next;
    logic [sexp_tok_pkg::LENGTH_BITS-1:0] len_reg, len_next;
    logic [sexp_tok_pkg::LINE_BITS-1:0]   line_reg, line_next;

    // ---------------- pipeline registers ----------------
    logic       ib_valid_reg;
    logic [7:0] ib_byte_reg;
    logic       ib_last_reg;

    logic        ob_valid_reg;
    logic [2:0]  ob_kind_reg;
    logic        ob_first_reg;
    logic        ob_here_reg;
    logic        ob_before_reg;
    logic [15:0] ob_len_reg;
    logic [15:0] ob_line_reg;
    logic        ob_over_reg;
    logic        ob_open_reg;

    // input stage hands its byte to the result stage
    logic advance;
    logic in_take;

    assign advance  = ib_valid_reg && (!ob_valid_reg || !out_stall);
    assign in_take  = in_valid && !in_stall;
    assign in_stall = ib_valid_reg && !advance;

    // ---------------- per-byte decode ----------------
    logic [7:0] b;
    logic       is_ws, is_nl, is_lp, is_rp, is_semi, is_dq, is_term;

    assign b       = ib_byte_reg;
    assign is_ws   = (b == sexp_tok_pkg::CH_SPACE) || (b == sexp_tok_pkg::CH_TAB);
    assign is_nl   = (b == sexp_tok_pkg::CH_NEWLINE);
    assign is_lp   = (b == sexp_tok_pkg::CH_LPAREN);
    assign is_rp   = (b == sexp_tok_pkg::CH_RPAREN);
    assign is_semi = (b == sexp_tok_pkg::CH_SEMI);
    assign is_dq   = (b == sexp_tok_pkg::CH_DQUOTE);
    assign is_term = is_ws || is_nl || is_semi || is_lp || is_rp;

    // result fields before the output register
    logic [2:0]                           r_kind;
    logic                                 r_first, r_here, r_before, r_over, r_open;
    logic [sexp_tok_pkg::LENGTH_BITS-1:0] r_len;

    logic [sexp_tok_pkg::LENGTH_BITS-1:0] len_up;
    logic [sexp_tok_pkg::NEST_BITS-1:0]   nest_upd;

    assign len_up = sexp_tok_pkg::len_inc(len_reg);

    always_comb
    begin
        r_kind    = sexp_tok_pkg::KIND_WS;
        r_first   = 1'b0;
        r_here    = 1'b0;
        r_before  = 1'b0;
        r_over    = 1'b0;
        r_open    = 1'b0;
        r_len     = '0;
        mode_next = mode_reg;
        pq_next   = pq_reg;
        pb_next   = pb_reg;
        nest_next = nest_reg;
        len_next  = len_reg;
        line_next = line_reg;
        nest_upd  = nest_reg;

        unique case (mode_reg)
            MODE_COMMENT:
            begin
                if (is_nl)
                begin
                    r_kind    = sexp_tok_pkg::KIND_WS;
                    line_next = sexp_tok_pkg::line_inc(line_reg);
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    r_kind = sexp_tok_pkg::KIND_COMMENT;
                end
            end

            MODE_STRING:
            begin
                r_kind   = sexp_tok_pkg::KIND_STRING;
                len_next = len_up;
                if (is_dq && !pb_reg)
                begin
                    r_here    = 1'b1;
                    r_len     = len_up;
                    len_next  = '0;
                    mode_next = MODE_IDLE;
                end
                pb_next = (b == sexp_tok_pkg::CH_BACKSLASH);
            end

            MODE_QLIST:
            begin
                r_kind   = sexp_tok_pkg::KIND_QLIST;
                len_next = len_up;
                if (is_lp)
                begin
                    if (nest_reg == sexp_tok_pkg::NEST_TOP)
                        r_over = 1'b1;
                    else
                        nest_upd = nest_reg + sexp_tok_pkg::NEST_BITS'(1);
                end
                else if (is_rp && (nest_reg != '0))
                begin
                    nest_upd = nest_reg - sexp_tok_pkg::NEST_BITS'(1);
                end
                nest_next = nest_upd;
                if (nest_upd == '0)
                begin
                    r_here    = 1'b1;
                    r_len     = len_up;
                    len_next  = '0;
                    mode_next = MODE_IDLE;
                end
            end

            MODE_ATOM, MODE_IDLE:
            begin
                if ((mode_reg == MODE_ATOM) && is_lp && pq_reg)
                begin
                    // quote mark then '(' opens a quoted list
                    r_kind    = sexp_tok_pkg::KIND_QLIST;
                    len_next  = len_up;
                    mode_next = MODE_QLIST;
                    nest_next = sexp_tok_pkg::NEST_BITS'(1);
                    pq_next   = 1'b0;
                end
                else if ((mode_reg == MODE_ATOM) && !is_term)
                begin
                    len_next = len_up;
                    if (is_dq)
                    begin
                        r_kind    = sexp_tok_pkg::KIND_STRING;
                        mode_next = MODE_STRING;
                        pb_next   = 1'b0;
                        pq_next   = 1'b0;
                    end
                    else
                    begin
                        r_kind  = sexp_tok_pkg::KIND_ATOM;
                        pq_next = (b == sexp_tok_pkg::CH_QUOTE);
                    end
                end
                else
                begin
                    // idle handling; an atom cut off by a terminator lands here too
                    mode_next = MODE_IDLE;
                    len_next  = '0;
                    pq_next   = 1'b0;
                    pb_next   = 1'b0;
                    if (is_ws)
                    begin
                        r_kind = sexp_tok_pkg::KIND_WS;
                    end
                    else if (is_nl)
                    begin
                        r_kind    = sexp_tok_pkg::KIND_WS;
                        line_next = sexp_tok_pkg::line_inc(line_reg);
                    end
                    else if (is_semi)
                    begin
                        r_kind    = sexp_tok_pkg::KIND_COMMENT;
                        mode_next = MODE_COMMENT;
                    end
                    else if (is_lp || is_rp)
                    begin
                        r_kind  = is_lp ? sexp_tok_pkg::KIND_OPEN : sexp_tok_pkg::KIND_CLOSE;
                        r_first = 1'b1;
                        r_here  = 1'b1;
                        r_len   = sexp_tok_pkg::LENGTH_BITS'(1);
                    end
                    else if (is_dq)
                    begin
                        r_kind    = sexp_tok_pkg::KIND_STRING;
                        r_first   = 1'b1;
                        mode_next = MODE_STRING;
                        len_next  = sexp_tok_pkg::LENGTH_BITS'(1);
                    end
                    else
                    begin
                        r_kind    = sexp_tok_pkg::KIND_ATOM;
                        r_first   = 1'b1;
                        mode_next = MODE_ATOM;
                        len_next  = sexp_tok_pkg::LENGTH_BITS'(1);
                        pq_next   = (b == sexp_tok_pkg::CH_QUOTE);
                    end
                    if (mode_reg == MODE_ATOM)
                    begin
                        // the atom's length wins over the lone paren's
                        r_before = 1'b1;
                        r_len    = len_reg;
                    end
                end
            end

            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase

        // last byte: close whatever is open, then back to reset state
        if (ib_last_reg)
        begin
            if ((mode_next == MODE_ATOM) || (mode_next == MODE_STRING) ||
                (mode_next == MODE_QLIST))
            begin
                r_here = 1'b1;
                r_len  = len_next;
                r_open = (mode_next != MODE_ATOM);
            end
            mode_next = MODE_IDLE;
            pq_next   = 1'b0;
            pb_next   = 1'b0;
            nest_next = '0;
            len_next  = '0;
            line_next = sexp_tok_pkg::LINE_BITS'(1);
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            pq_reg       <= 1'b0;
            pb_reg       <= 1'b0;
            nest_reg     <= '0;
            len_reg      <= '0;
            line_reg     <= sexp_tok_pkg::LINE_BITS'(1);
            ib_valid_reg <= 1'b0;
            ob_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                ib_valid_reg <= 1'b1;
            else if (advance)
                ib_valid_reg <= 1'b0;

            if (advance)
            begin
                ob_valid_reg <= 1'b1;
                mode_reg     <= mode_next;
                pq_reg       <= pq_next;
                pb_reg       <= pb_next;
                nest_reg     <= nest_next;
                len_reg      <= len_next;
                line_reg     <= line_next;
            end
            else if (!out_stall)
            begin
                ob_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            ib_byte_reg <= in_byte;
            ib_last_reg <= last;
        end
        if (advance)
        begin
            ob_kind_reg   <= r_kind;
            ob_first_reg  <= r_first;
            ob_here_reg   <= r_here;
            ob_before_reg <= r_before;
            ob_len_reg    <= sexp_tok_pkg::len_clip(r_len);
            ob_line_reg   <= sexp_tok_pkg::line_clip(line_reg);
            ob_over_reg   <= r_over;
            ob_open_reg   <= r_open;
        end
    end

    assign out_valid      = ob_valid_reg;
    assign byte_kind      = ob_kind_reg;
    assign token_first    = ob_first_reg;
    assign ends_here      = ob_here_reg;
    assign ended_before   = ob_before_reg;
    assign token_length   = ob_len_reg;
    assign line_number    = ob_line_reg;
    assign depth_overflow = ob_over_reg;
    assign unclosed       = ob_open_reg;

endmodule

// File: dv/testbench.sv
// Self-checking testbench for s_expression_tokenizer: source bytes in, one token result per byte.
// Holds its own tokenizer predictor; depends on sexp_tok_pkg and the tokenizer RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int RANDOM_ITEMS   = 700;
    localparam int NEST_RUN       = 260;    // opens past the nesting limit inside a quoted list
    localparam int HOLD_CYCLES    = 300;    // receiver hold-off, long enough to back up the input
    localparam int WATCHDOG_LIMIT = 2000;   // cycles with no transaction on either side
    localparam int DRAIN_CYCLES   = 8;      // two-stage pipe, plus margin
    localparam int MAX_REPORTS    = 40;

    // Tokenizer mode, tracked by the predictor only
    typedef enum logic [2:0] {TM_IDLE, TM_COMMENT, TM_ATOM, TM_STRING, TM_QLIST} tok_mode_t;

    // One result transaction, at port widths
    typedef struct packed {
        logic [2:0]  kind;
        logic        first;
        logic        here;
        logic        cut;
        logic [15:0] len;
        logic [15:0] line;
        logic        over;
        logic        open_end;
    } tok_result_t;

    // Directed stimulus row; pinned rows carry a hand-written expectation
    typedef struct {
        logic [7:0]  b;
        logic        fin;
        logic        pinned;
        tok_result_t want;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte = '0;
    logic        last = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  byte_kind;
    logic        token_first;
    logic        ends_here;
    logic        ended_before;
    logic [15:0] token_length;
    logic [15:0] line_number;
    logic        depth_overflow;
    logic        unclosed;

    s_expression_tokenizer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_byte        (in_byte),
        .last           (last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .byte_kind      (byte_kind),
        .token_first    (token_first),
        .ends_here      (ends_here),
        .ended_before   (ended_before),
        .token_length   (token_length),
        .line_number    (line_number),
        .depth_overflow (depth_overflow),
        .unclosed       (unclosed)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Tokenizer predictor state
    // ------------------------------------------------------------------
    tok_mode_t                            tmode;
    logic                                 quote_seen;    // previous atom byte was a quote mark
    logic                                 escape_seen;   // previous string byte was a backslash
    logic [sexp_tok_pkg::NEST_BITS-1:0]   nest_depth;
    logic [sexp_tok_pkg::LENGTH_BITS-1:0] tok_len;
    logic [sexp_tok_pkg::LINE_BITS-1:0]   line_cnt;

    // Expected results, oldest first
    tok_result_t pending[$];

    // Run bookkeeping
    int  fail_count      = 0;
    int  bytes_sent      = 0;
    int  results_checked = 0;
    int  ends_seen       = 0;
    int  overflows_seen  = 0;
    int  unclosed_seen   = 0;
    int  holds_done      = 0;
    int  quiet_cycles    = 0;
    bit  quiet_tx        = 1'b0;   // sender offers back to back
    bit  quiet_rx        = 1'b0;   // receiver never stalls, apart from a requested hold-off
    bit  hold_req        = 1'b0;   // ask the receiver for one long hold-off

    logic [7:0] text_q[$];
    dir_row_t   dir_tab[$];

    function automatic void clear_tracker();
        tmode       = TM_IDLE;
        quote_seen  = 1'b0;
        escape_seen = 1'b0;
        nest_depth  = '0;
        tok_len     = '0;
        line_cnt    = sexp_tok_pkg::LINE_BITS'(1);
    endfunction

    function automatic void grow_token();
        if (tok_len != '1)
            tok_len = tok_len + 1'b1;
    endfunction

    function automatic void next_line();
        if (line_cnt != '1)
            line_cnt = line_cnt + 1'b1;
    endfunction

    function automatic logic [15:0] clip16(input logic [31:0] v);
        return (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
    endfunction

    // Bytes that cut an atom off
    function automatic logic is_break(input logic [7:0] b);
        return b == sexp_tok_pkg::CH_SPACE || b == sexp_tok_pkg::CH_TAB ||
               b == sexp_tok_pkg::CH_NEWLINE || b == sexp_tok_pkg::CH_SEMI ||
               b == sexp_tok_pkg::CH_LPAREN || b == sexp_tok_pkg::CH_RPAREN;
    endfunction

    // Byte seen with no token open
    function automatic void start_from_idle(input logic [7:0] b, inout tok_result_t r);
        quote_seen  = 1'b0;
        escape_seen = 1'b0;
        case (b)
            sexp_tok_pkg::CH_SPACE, sexp_tok_pkg::CH_TAB:
                r.kind = sexp_tok_pkg::KIND_WS;
            sexp_tok_pkg::CH_NEWLINE:
            begin
                r.kind = sexp_tok_pkg::KIND_WS;
                next_line();
            end
            sexp_tok_pkg::CH_SEMI:
            begin
                r.kind = sexp_tok_pkg::KIND_COMMENT;
                tmode  = TM_COMMENT;
            end
            sexp_tok_pkg::CH_LPAREN, sexp_tok_pkg::CH_RPAREN:
            begin
                r.kind  = (b == sexp_tok_pkg::CH_LPAREN) ? sexp_tok_pkg::KIND_OPEN
                                                         : sexp_tok_pkg::KIND_CLOSE;
                r.first = 1'b1;
                r.here  = 1'b1;
                r.len   = 16'd1;
            end
            sexp_tok_pkg::CH_DQUOTE:
            begin
                r.kind  = sexp_tok_pkg::KIND_STRING;
                r.first = 1'b1;
                tmode   = TM_STRING;
                tok_len = sexp_tok_pkg::LENGTH_BITS'(1);
            end
            default:
            begin
                r.kind     = sexp_tok_pkg::KIND_ATOM;
                r.first    = 1'b1;
                tmode      = TM_ATOM;
                tok_len    = sexp_tok_pkg::LENGTH_BITS'(1);
                quote_seen = (b == sexp_tok_pkg::CH_QUOTE);
            end
        endcase
    endfunction

    // Expected result for one accepted byte; advances the tracker
    function automatic tok_result_t tokenize(input logic [7:0] b, input logic fin);
        tok_result_t                          r;
        logic [15:0]                          line_at;
        logic [sexp_tok_pkg::LENGTH_BITS-1:0] atom_len;
        r       = '0;
        line_at = clip16(32'(line_cnt));   // line before this byte's own newline
        case (tmode)
            TM_COMMENT:
            begin
                if (b == sexp_tok_pkg::CH_NEWLINE)
                begin
                    r.kind = sexp_tok_pkg::KIND_WS;
                    next_line();
                    tmode = TM_IDLE;
                end
                else
                    r.kind = sexp_tok_pkg::KIND_COMMENT;
            end
            TM_ATOM:
            begin
                if (b == sexp_tok_pkg::CH_LPAREN && quote_seen)
                begin
                    // quote mark then '(' turns the atom into a quoted list
                    r.kind = sexp_tok_pkg::KIND_QLIST;
                    grow_token();
                    tmode      = TM_QLIST;
                    nest_depth = sexp_tok_pkg::NEST_BITS'(1);
                    quote_seen = 1'b0;
                end
                else if (is_break(b))
                begin
                    // atom closes before this byte, which is then handled on its own
                    atom_len = tok_len;
                    tok_len  = '0;
                    tmode    = TM_IDLE;
                    start_from_idle(b, r);
                    r.cut = 1'b1;
                    r.len = clip16(32'(atom_len));
                end
                else if (b == sexp_tok_pkg::CH_DQUOTE)
                begin
                    r.kind = sexp_tok_pkg::KIND_STRING;
                    grow_token();
                    tmode       = TM_STRING;
                    escape_seen = 1'b0;
                    quote_seen  = 1'b0;
                end
                else
                begin
                    r.kind = sexp_tok_pkg::KIND_ATOM;
                    grow_token();
                    quote_seen = (b == sexp_tok_pkg::CH_QUOTE);
                end
            end
            TM_STRING:
            begin
                r.kind = sexp_tok_pkg::KIND_STRING;
                grow_token();
                if (b == sexp_tok_pkg::CH_DQUOTE && !escape_seen)
                begin
                    r.here  = 1'b1;
                    r.len   = clip16(32'(tok_len));
                    tok_len = '0;
                    tmode   = TM_IDLE;
                end
                escape_seen = (b == sexp_tok_pkg::CH_BACKSLASH);
            end
            TM_QLIST:
            begin
                r.kind = sexp_tok_pkg::KIND_QLIST;
                grow_token();
                if (b == sexp_tok_pkg::CH_LPAREN)
                begin
                    if (nest_depth == '1)
                        r.over = 1'b1;
                    else
                        nest_depth = nest_depth + 1'b1;
                end
                else if (b == sexp_tok_pkg::CH_RPAREN && nest_depth != '0)
                    nest_depth = nest_depth - 1'b1;
                if (nest_depth == '0)
                begin
                    r.here  = 1'b1;
                    r.len   = clip16(32'(tok_len));
                    tok_len = '0;
                    tmode   = TM_IDLE;
                end
            end
            default:
                start_from_idle(b, r);
        endcase
        // last byte: close whatever is open, then back to reset state
        if (fin)
        begin
            if (tmode == TM_ATOM || tmode == TM_STRING || tmode == TM_QLIST)
            begin
                r.here     = 1'b1;
                r.len      = clip16(32'(tok_len));
                r.open_end = (tmode != TM_ATOM);
            end
            clear_tracker();
        end
        r.line = line_at;
        return r;
    endfunction

    function automatic tok_result_t result_of(input logic [2:0] kind, input logic first,
                                              input logic here, input logic cut,
                                              input logic [15:0] len, input logic [15:0] line,
                                              input logic over, input logic open_end);
        tok_result_t r;
        r.kind     = kind;
        r.first    = first;
        r.here     = here;
        r.cut      = cut;
        r.len      = len;
        r.line     = line;
        r.over     = over;
        r.open_end = open_end;
        return r;
    endfunction

    function automatic dir_row_t plain_row(input logic [7:0] b, input logic fin);
        dir_row_t d;
        d.b      = b;
        d.fin    = fin;
        d.pinned = 1'b0;
        d.want   = '0;
        return d;
    endfunction

    function automatic dir_row_t pinned_row(input logic [7:0] b, input logic fin,
                                            input tok_result_t want);
        dir_row_t d;
        d        = plain_row(b, fin);
        d.pinned = 1'b1;
        d.want   = want;
        return d;
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Random text: well-formed fragments with random content, some noise
    // ------------------------------------------------------------------
    function automatic logic [7:0] atom_byte();
        logic [7:0] c;
        if ($urandom_range(0, 99) < 12)
            return sexp_tok_pkg::CH_QUOTE;
        do
            c = 8'($urandom_range(0, 255));
        while (is_break(c) || c == sexp_tok_pkg::CH_DQUOTE);
        return c;
    endfunction

    function automatic void add_fragment();
        int         r;
        int         n;
        int         depth;
        logic [7:0] c;
        r = $urandom_range(0, 99);
        if (r < 25)
        begin
            // atom, sometimes running into a string, then maybe a terminator
            n = $urandom_range(1, 8);
            repeat (n) text_q.push_back(atom_byte());
            if ($urandom_range(0, 9) == 0)
                text_q.push_back(sexp_tok_pkg::CH_DQUOTE);
            else if ($urandom_range(0, 2) != 0)
            begin
                case ($urandom_range(0, 5))
                    0: text_q.push_back(sexp_tok_pkg::CH_SPACE);
                    1: text_q.push_back(sexp_tok_pkg::CH_TAB);
                    2: text_q.push_back(sexp_tok_pkg::CH_NEWLINE);
                    3: text_q.push_back(sexp_tok_pkg::CH_SEMI);
                    4: text_q.push_back(sexp_tok_pkg::CH_LPAREN);
                    default: text_q.push_back(sexp_tok_pkg::CH_RPAREN);
                endcase
            end
        end
        else if (r < 37)
        begin
            // string with escapes and embedded newlines
            text_q.push_back(sexp_tok_pkg::CH_DQUOTE);
            n = $urandom_range(0, 10);
            repeat (n)
            begin
                case ($urandom_range(0, 9))
                    0, 1:
                    begin
                        text_q.push_back(sexp_tok_pkg::CH_BACKSLASH);
                        if ($urandom_range(0, 1))
                            text_q.push_back(sexp_tok_pkg::CH_DQUOTE);
                    end
                    2: text_q.push_back(sexp_tok_pkg::CH_NEWLINE);
                    default:
                    begin
                        do
                            c = 8'($urandom_range(0, 255));
                        while (c == sexp_tok_pkg::CH_DQUOTE);
                        text_q.push_back(c);
                    end
                endcase
            end
            text_q.push_back(sexp_tok_pkg::CH_DQUOTE);
        end
        else if (r < 50)
        begin
            // quoted list, balanced, with nesting and mixed body
            if ($urandom_range(0, 3) == 0)
                text_q.push_back(atom_byte());
            text_q.push_back(sexp_tok_pkg::CH_QUOTE);
            text_q.push_back(sexp_tok_pkg::CH_LPAREN);
            depth = 1;
            n = $urandom_range(0, 12);
            while (n > 0 && depth > 0)
            begin
                case ($urandom_range(0, 6))
                    0:
                    begin
                        if (depth < 4)
                        begin
                            text_q.push_back(sexp_tok_pkg::CH_LPAREN);
                            depth++;
                        end
                    end
                    1:
                    begin
                        text_q.push_back(sexp_tok_pkg::CH_RPAREN);
                        depth--;
                    end
                    2: text_q.push_back(sexp_tok_pkg::CH_NEWLINE);
                    3: text_q.push_back($urandom_range(0, 1) ? sexp_tok_pkg::CH_DQUOTE
                                                             : sexp_tok_pkg::CH_BACKSLASH);
                    4: text_q.push_back(sexp_tok_pkg::CH_SPACE);
                    default: text_q.push_back(atom_byte());
                endcase
                n--;
            end
            while (depth > 0)
            begin
                text_q.push_back(sexp_tok_pkg::CH_RPAREN);
                depth--;
            end
        end
        else if (r < 60)
        begin
            // comment to end of line
            text_q.push_back(sexp_tok_pkg::CH_SEMI);
            n = $urandom_range(0, 8);
            repeat (n)
            begin
                do
                    c = 8'($urandom_range(0, 255));
                while (c == sexp_tok_pkg::CH_NEWLINE);
                text_q.push_back(c);
            end
            text_q.push_back(sexp_tok_pkg::CH_NEWLINE);
        end
        else if (r < 74)
        begin
            case ($urandom_range(0, 2))
                0: text_q.push_back(sexp_tok_pkg::CH_SPACE);
                1: text_q.push_back(sexp_tok_pkg::CH_TAB);
                default: text_q.push_back(sexp_tok_pkg::CH_NEWLINE);
            endcase
        end
        else if (r < 86)
            text_q.push_back($urandom_range(0, 1) ? sexp_tok_pkg::CH_LPAREN
                                                  : sexp_tok_pkg::CH_RPAREN);
        else
            text_q.push_back(8'($urandom_range(0, 255)));   // noise: any byte
    endfunction

    // ------------------------------------------------------------------
    // Sender: one input transaction, prediction made at acceptance
    // ------------------------------------------------------------------
    task automatic put_byte(input logic [7:0] b, input logic fin, input logic pinned,
                            input tok_result_t want);
        int          gap;
        tok_result_t e;
        gap = quiet_tx ? 0 : idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        last     <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        e = tokenize(b, fin);
        // a pinned row's typed-in expectation stands in for the predictor's
        if (pinned)
            e = want;
        pending.push_back(e);
        bytes_sent++;
        if (e.here || e.cut)
            ends_seen++;
        if (e.over)
            overflows_seen++;
        if (e.open_end)
            unclosed_seen++;
    endtask

    task automatic send(input logic [7:0] b, input logic fin);
        put_byte(b, fin, 1'b0, '0);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall stretches, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin : rx_stall_driver
        int n;
        forever
        begin
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                holds_done++;
            end
            else if (quiet_rx)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                n = idle_len();
                if (n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result check: every accepted result against the oldest expectation
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        tok_result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending.size() == 0)
            begin
                fail_count++;
                $error("result transaction with no byte outstanding");
            end
            else
            begin
                e = pending.pop_front();
                check_field("byte_kind",      16'(e.kind),     16'(byte_kind));
                check_field("token_first",    16'(e.first),    16'(token_first));
                check_field("ends_here",      16'(e.here),     16'(ends_here));
                check_field("ended_before",   16'(e.cut),      16'(ended_before));
                check_field("token_length",   e.len,           token_length);
                check_field("line_number",    e.line,          line_number);
                check_field("depth_overflow", 16'(e.over),     16'(depth_overflow));
                check_field("unclosed",       16'(e.open_end), 16'(unclosed));
                results_checked++;
            end
        end
    end

    // Watchdog: too long with no transaction on either channel ends the run
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("testbench failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        int rand_sent;
        int target;
        rand_sent = 0;
        clear_tracker();

        // Directed text: extremes, every byte kind, both end flags at once,
        // an escaped quote, a newline inside a string and a quoted list,
        // comment to newline, and texts ending inside an atom and a string.
        dir_tab.push_back(pinned_row(sexp_tok_pkg::CH_SPACE, 1'b0,
                          result_of(sexp_tok_pkg::KIND_WS, 0, 0, 0, 16'd0, 16'd1, 0, 0)));
        dir_tab.push_back(pinned_row(8'h00, 1'b0,
                          result_of(sexp_tok_pkg::KIND_ATOM, 1, 0, 0, 16'd0, 16'd1, 0, 0)));
        dir_tab.push_back(plain_row(8'hFF, 1'b0));
        // paren cuts the atom off and is a token of its own
        dir_tab.push_back(pinned_row(sexp_tok_pkg::CH_LPAREN, 1'b0,
                          result_of(sexp_tok_pkg::KIND_OPEN, 1, 1, 1, 16'd2, 16'd1, 0, 0)));
        dir_tab.push_back(plain_row("a", 1'b0));
        dir_tab.push_back(plain_row(sexp_tok_pkg::CH_DQUOTE, 1'b0));     // atom runs into a string
        dir_tab.push_back(plain_row(sexp_tok_pkg::CH_BACKSLASH, 1'b0));
        dir_tab.push_back(plain_row(sexp_tok_pkg::CH_DQUOTE, 1'b0));     // escaped, string goes on
        dir_tab.push_back(plain_row(sexp_tok_pkg::CH_NEWLINE, 1'b0));    // no line advance
        dir_tab.push_back(plain_row(sexp_tok_pkg::CH_DQUOTE, 1'b0));
        dir_tab.push_back(plain_row(sexp_tok_pkg::CH_SEMI, 1'b0));
        dir_tab.push_back(plain_row("x", 1'b0));
        dir_tab.push_back(plain_row(sexp_tok_pkg::CH_NEWLINE, 1'b0));    // ends the comment
        dir_tab.push_back(plain_row(sexp_tok_pkg::CH_QUOTE, 1'b0));
        dir_tab.push_back(plain_row(sexp_tok_pkg::CH_LPAREN, 1'b0));     // quoted list opens
        dir_tab.push_back(plain_row(sexp_tok_pkg::CH_NEWLINE, 1'b0));
        dir_tab.push_back(plain_row(sexp_tok_pkg::CH_LPAREN, 1'b0));
        dir_tab.push_back(plain_row(sexp_tok_pkg::CH_RPAREN, 1'b0));
        dir_tab.push_back(plain_row(sexp_tok_pkg::CH_RPAREN, 1'b0));     // balancing paren
        dir_tab.push_back(pinned_row(sexp_tok_pkg::CH_RPAREN, 1'b0,
                          result_of(sexp_tok_pkg::KIND_CLOSE, 1, 1, 0, 16'd1, 16'd2, 0, 0)));
        dir_tab.push_back(plain_row(sexp_tok_pkg::CH_TAB, 1'b0));
        dir_tab.push_back(plain_row("b", 1'b0));
        dir_tab.push_back(pinned_row("c", 1'b1,
                          result_of(sexp_tok_pkg::KIND_ATOM, 0, 1, 0, 16'd2, 16'd2, 0, 0)));
        dir_tab.push_back(plain_row(sexp_tok_pkg::CH_DQUOTE, 1'b0));
        dir_tab.push_back(pinned_row("z", 1'b1,
                          result_of(sexp_tok_pkg::KIND_STRING, 0, 1, 0, 16'd2, 16'd1, 0, 1)));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
            put_byte(dir_tab[i].b, dir_tab[i].fin, dir_tab[i].pinned, dir_tab[i].want);

        // Random texts; about half are cut short so tokens stay open at the end
        while (rand_sent < RANDOM_ITEMS)
        begin
            target = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4)
                                                 : $urandom_range(10, 120);
            text_q.delete();
            while (text_q.size() < target)
                add_fragment();
            if ($urandom_range(0, 1))
                text_q = text_q[0:target-1];
            quiet_tx = ($urandom_range(0, 4) == 0);
            quiet_rx = ($urandom_range(0, 4) == 0);
            foreach (text_q[i])
            begin
                // midway: receiver holds off while bytes keep coming
                if (rand_sent == RANDOM_ITEMS / 2)
                begin
                    hold_req = 1'b1;
                    quiet_tx = 1'b1;
                end
                send(text_q[i], i == text_q.size() - 1);
                rand_sent++;
            end
        end

        // Nesting limit inside a quoted list, then close it down to zero
        quiet_tx = 1'b0;
        quiet_rx = 1'b0;
        send(sexp_tok_pkg::CH_QUOTE, 1'b0);
        send(sexp_tok_pkg::CH_LPAREN, 1'b0);
        repeat (NEST_RUN) send(sexp_tok_pkg::CH_LPAREN, 1'b0);
        repeat (int'(sexp_tok_pkg::NEST_TOP)) send(sexp_tok_pkg::CH_RPAREN, 1'b0);
        send(sexp_tok_pkg::CH_SPACE, 1'b1);

        in_valid <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d bytes: directed text, random texts, quoted-list nesting limit.",
                 bytes_sent);
        $display("%0d results checked; %0d token ends, %0d depth overflows,",
                 results_checked, ends_seen, overflows_seen);
        $display("%0d unclosed texts, %0d receiver hold-offs.", unclosed_seen, holds_done);
        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

// File: s_expression_tokenizer.f
rtl/sexp_tok_pkg.sv
rtl/s_expression_tokenizer.sv
dv/testbench.sv
